>>> design/dpvd_pkg.sv
// shared constants, types and helpers of the dual pulse-rate velocity dealias unit
`timescale 1ns / 1ps

package dpvd_pkg;

    // unfold multipliers 0,+1,-1,+2,-2,... taken per velocity
    localparam int NUM_INTERVALS = 7;
    localparam int IDX_W         = (NUM_INTERVALS > 1) ? $clog2(NUM_INTERVALS) : 1;

    // field widths
    localparam int VEL_W  = 12;
    localparam int NYQ_W  = 11;
    localparam int CAP_W  = 13;
    localparam int THR_W  = 8;
    localparam int OUT_W  = 15;

    // internal widths: unfolded candidate, pair sum/difference, rounding magnitude
    localparam int CAND_W = 16;
    localparam int SUM_W  = CAND_W + 1;
    localparam int MAG_W  = 15;
    localparam int PROD_W = 2 * NYQ_W;

    // divide by five as multiply by reciprocal and shift
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 18;
    localparam logic [RECIP_W-1:0] RECIP_FIVE = RECIP_W'(((1 << RECIP_SHIFT) + 4) / 5);
    localparam int Q_W = MAG_W + RECIP_W - RECIP_SHIFT;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CAP_W;
    localparam logic [CFG_IDX_W-1:0] REG_NYQ_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NYQ_SECOND = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_UNFOLD_CAP = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THR  = CFG_IDX_W'(3);

    // register reset values
    localparam int RST_NYQ_FIRST  = 1;
    localparam int RST_NYQ_SECOND = 2;
    localparam int RST_CAP        = 1000;
    localparam int RST_THR        = 30;
    localparam int RST_DIFF       = (RST_NYQ_SECOND > RST_NYQ_FIRST) ?
                                    (RST_NYQ_SECOND - RST_NYQ_FIRST) :
                                    (RST_NYQ_FIRST - RST_NYQ_SECOND);
    localparam int RST_EQ         = (RST_NYQ_FIRST * RST_NYQ_SECOND) / RST_DIFF;
    localparam logic [CAP_W-1:0] RESET_LIMIT = CAP_W'((RST_EQ < RST_CAP) ? RST_EQ : RST_CAP);

    typedef logic signed [CAND_W-1:0] cand_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // selected pair handed from the match pipeline to the rounding pipeline
    typedef struct packed {
        logic  valid;
        logic  found;
        logic  invalid;
        logic  exact;
        cand_t v1;
        sum_t  sum;
    } pair_t;

    // signed unfold offset of multiplier k: +-((k+1)/2) * 2 * nyquist
    function automatic cand_t cand_offset(input int k, input logic [NYQ_W-1:0] nyq);
        logic [CAND_W-1:0] twice_n;
        logic [CAND_W-1:0] scaled;
        twice_n = {{(CAND_W-NYQ_W-1){1'b0}}, nyq, 1'b0};
        scaled  = twice_n * CAND_W'((k + 1) >> 1);
        return (k % 2 == 1) ? cand_t'(scaled) : -cand_t'(scaled);
    endfunction

endpackage

>>> design/dpvd_limit_div.sv
// velocity limit unit: equivalent nyquist by restoring division, capped
`timescale 1ns / 1ps

module dpvd_limit_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dpvd_pkg::NYQ_W-1:0]    nyquist_first,
    input  logic [dpvd_pkg::NYQ_W-1:0]    nyquist_second,
    input  logic [dpvd_pkg::CAP_W-1:0]    unfold_cap,
    output logic                          busy,
    output logic [dpvd_pkg::CAP_W-1:0]    limit
);
    import dpvd_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] dividend_reg, dividend_next;
    logic [NYQ_W-1:0]  divisor_reg, divisor_next;
    logic [NYQ_W-1:0]  rem_reg, rem_next;
    logic [CAP_W-1:0]  limit_reg, limit_next;

    logic [NYQ_W:0]    rem_shift;
    logic [NYQ_W:0]    rem_sub;
    logic              rem_ge;

    // one quotient bit per step
    always_comb
    begin
        rem_shift = {rem_reg, dividend_reg[PROD_W-1]};
        rem_sub   = rem_shift - {1'b0, divisor_reg};
        rem_ge    = (rem_shift >= {1'b0, divisor_reg});
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        limit_next    = limit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_LOAD:
            begin
                dividend_next = PROD_W'(nyquist_first) * PROD_W'(nyquist_second);
                divisor_next  = (nyquist_first > nyquist_second) ?
                                (nyquist_first - nyquist_second) :
                                (nyquist_second - nyquist_first);
                rem_next      = '0;
                cnt_next      = '0;
                state_next    = ST_RUN;
            end
            ST_RUN:
            begin
                rem_next      = rem_ge ? rem_sub[NYQ_W-1:0] : rem_shift[NYQ_W-1:0];
                dividend_next = {dividend_reg[PROD_W-2:0], rem_ge};
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                limit_next = (dividend_reg > PROD_W'(unfold_cap)) ?
                             unfold_cap : dividend_reg[CAP_W-1:0];
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // a new register write restarts the computation
        if (start)
        begin
            state_next = ST_LOAD;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            limit_reg <= RESET_LIMIT;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            limit_reg <= limit_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
    end

    assign busy  = (state_reg != ST_IDLE);
    assign limit = limit_reg;

endmodule

>>> design/dpvd_cand_match.sv
// candidate unfolding, limit check, pair matching and first-match selection pipeline
`timescale 1ns / 1ps

module dpvd_cand_match (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [dpvd_pkg::VEL_W-1:0]  velocity_first,
    input  logic signed [dpvd_pkg::VEL_W-1:0]  velocity_second,
    input  logic [dpvd_pkg::NYQ_W-1:0]         nyquist_first,
    input  logic [dpvd_pkg::NYQ_W-1:0]         nyquist_second,
    input  logic [dpvd_pkg::CAP_W-1:0]         limit,
    input  logic [dpvd_pkg::THR_W-1:0]         match_threshold,
    output dpvd_pkg::pair_t                    pair
);
    import dpvd_pkg::*;

    // stage a: unfolded candidates
    logic  a_valid_reg, a_invalid_reg;
    cand_t a_v1_reg [NUM_INTERVALS];
    cand_t a_v2_reg [NUM_INTERVALS];
    cand_t a_v1_next [NUM_INTERVALS];
    cand_t a_v2_next [NUM_INTERVALS];

    // stage b: limit flags
    logic  b_valid_reg, b_invalid_reg;
    cand_t b_v1_reg [NUM_INTERVALS];
    cand_t b_v2_reg [NUM_INTERVALS];
    logic [NUM_INTERVALS-1:0] b_ok1_reg, b_ok2_reg, b_ok1_next, b_ok2_next;
    cand_t limit_pos, limit_neg;

    // stage c: pair match matrix, row k holds first-rate multiplier k
    logic  c_valid_reg, c_invalid_reg;
    cand_t c_v1_reg [NUM_INTERVALS];
    cand_t c_v2_reg [NUM_INTERVALS];
    logic [NUM_INTERVALS-1:0] c_match_reg  [NUM_INTERVALS];
    logic [NUM_INTERVALS-1:0] c_match_next [NUM_INTERVALS];
    sum_t thr_pos, thr_neg;

    // stage d: selected pair index
    logic  d_valid_reg, d_invalid_reg, d_found_reg;
    cand_t d_v1_reg [NUM_INTERVALS];
    cand_t d_v2_reg [NUM_INTERVALS];
    logic [IDX_W-1:0] d_k_reg, d_l_reg;
    logic [NUM_INTERVALS-1:0] row_hit;
    logic [IDX_W-1:0] first_l [NUM_INTERVALS];
    logic [IDX_W-1:0] sel_k, sel_l;

    // stage e: selected values and their sum
    pair_t pair_reg, pair_next;
    cand_t v1_sel, v2_sel;

    // unfold both velocities by every multiplier
    always_comb
    begin
        for (int k = 0; k < NUM_INTERVALS; k++)
        begin
            a_v1_next[k] = CAND_W'(velocity_first)  + cand_offset(k, nyquist_first);
            a_v2_next[k] = CAND_W'(velocity_second) + cand_offset(k, nyquist_second);
        end
    end

    // magnitude within the velocity limit
    always_comb
    begin
        limit_pos = cand_t'({{(CAND_W-CAP_W){1'b0}}, limit});
        limit_neg = -limit_pos;
        for (int k = 0; k < NUM_INTERVALS; k++)
        begin
            b_ok1_next[k] = (a_v1_reg[k] <= limit_pos) && (a_v1_reg[k] >= limit_neg);
            b_ok2_next[k] = (a_v2_reg[k] <= limit_pos) && (a_v2_reg[k] >= limit_neg);
        end
    end

    // every pair of usable candidates within the threshold
    always_comb
    begin
        sum_t diff;
        thr_pos = sum_t'({{(SUM_W-THR_W){1'b0}}, match_threshold});
        thr_neg = -thr_pos;
        for (int k = 0; k < NUM_INTERVALS; k++)
        begin
            for (int l = 0; l < NUM_INTERVALS; l++)
            begin
                diff = SUM_W'(b_v1_reg[k]) - SUM_W'(b_v2_reg[l]);
                c_match_next[k][l] = b_ok1_reg[k] && b_ok2_reg[l] &&
                                     (diff <= thr_pos) && (diff >= thr_neg);
            end
        end
    end

    // first match, first-rate multiplier major
    always_comb
    begin
        for (int k = 0; k < NUM_INTERVALS; k++)
        begin
            row_hit[k] = |c_match_reg[k];
            first_l[k] = '0;
            for (int l = NUM_INTERVALS - 1; l >= 0; l--)
            begin
                if (c_match_reg[k][l])
                begin
                    first_l[k] = IDX_W'(l);
                end
            end
        end
        sel_k = '0;
        for (int k = NUM_INTERVALS - 1; k >= 0; k--)
        begin
            if (row_hit[k])
            begin
                sel_k = IDX_W'(k);
            end
        end
        sel_l = first_l[sel_k];
    end

    // pick the winning candidates
    always_comb
    begin
        v1_sel            = d_v1_reg[d_k_reg];
        v2_sel            = d_v2_reg[d_l_reg];
        pair_next.valid   = d_valid_reg;
        pair_next.found   = d_found_reg;
        pair_next.invalid = d_invalid_reg;
        pair_next.exact   = (v1_sel == v2_sel);
        pair_next.v1      = v1_sel;
        pair_next.sum     = SUM_W'(v1_sel) + SUM_W'(v2_sel);
    end

    // valid bits along the stages, output pair register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            pair_reg    <= '0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            pair_reg    <= pair_next;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        a_invalid_reg    <= (nyquist_first == nyquist_second);
        a_v1_reg         <= a_v1_next;
        a_v2_reg         <= a_v2_next;
        b_invalid_reg    <= a_invalid_reg;
        b_v1_reg         <= a_v1_reg;
        b_v2_reg         <= a_v2_reg;
        b_ok1_reg        <= b_ok1_next;
        b_ok2_reg        <= b_ok2_next;
        c_invalid_reg    <= b_invalid_reg;
        c_v1_reg         <= b_v1_reg;
        c_v2_reg         <= b_v2_reg;
        c_match_reg      <= c_match_next;
        d_invalid_reg    <= c_invalid_reg;
        d_v1_reg         <= c_v1_reg;
        d_v2_reg         <= c_v2_reg;
        d_found_reg      <= |row_hit;
        d_k_reg          <= sel_k;
        d_l_reg          <= sel_l;
    end

    assign pair = pair_reg;

endmodule

>>> design/dpvd_round.sv
// halving, round to nearest multiple of five and result register
`timescale 1ns / 1ps

module dpvd_round (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dpvd_pkg::pair_t                    pair,
    output logic                               done,
    output logic signed [dpvd_pkg::OUT_W-1:0]  unfolded_velocity,
    output logic                               found,
    output logic                               config_invalid
);
    import dpvd_pkg::*;

    // stage f: magnitude of the truncated average plus two
    logic             f_valid_reg, f_found_reg, f_invalid_reg, f_exact_reg, f_neg_reg;
    logic [OUT_W-1:0] f_v1_reg;
    logic [MAG_W-1:0] f_x_reg, f_x_next;
    sum_t             sum_adj, half, mag_full;

    // stage g: quotient by five
    logic             g_valid_reg, g_found_reg, g_invalid_reg, g_exact_reg, g_neg_reg;
    logic [OUT_W-1:0] g_v1_reg;
    logic [Q_W-1:0]   g_q_reg;
    logic [MAG_W+RECIP_W-1:0] prod;

    // stage h: output register
    logic                    done_reg, found_reg, invalid_reg;
    logic signed [OUT_W-1:0] vel_reg, vel_next;
    logic [OUT_W-1:0]        rounded;

    // average truncated toward zero, then magnitude
    always_comb
    begin
        sum_adj  = pair.sum + (pair.sum[SUM_W-1] ? sum_t'(1) : sum_t'(0));
        half     = sum_adj >>> 1;
        mag_full = half[SUM_W-1] ? -half : half;
        f_x_next = MAG_W'(mag_full + sum_t'(2));
    end

    // reciprocal multiply
    always_comb
    begin
        prod = (MAG_W+RECIP_W)'(f_x_reg) * (MAG_W+RECIP_W)'(RECIP_FIVE);
    end

    // back to a multiple of five, restore sign, pick the case
    always_comb
    begin
        rounded = OUT_W'({g_q_reg, 2'b00}) + OUT_W'(g_q_reg);
        if (g_invalid_reg || !g_found_reg)
        begin
            vel_next = '0;
        end
        else if (g_exact_reg)
        begin
            vel_next = $signed(g_v1_reg);
        end
        else
        begin
            vel_next = g_neg_reg ? -$signed(rounded) : $signed(rounded);
        end
    end

    // valid bits and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            f_valid_reg <= pair.valid;
            g_valid_reg <= f_valid_reg;
            done_reg    <= g_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        f_found_reg   <= pair.found;
        f_invalid_reg <= pair.invalid;
        f_exact_reg   <= pair.exact;
        f_neg_reg     <= half[SUM_W-1];
        f_v1_reg      <= pair.v1[OUT_W-1:0];
        f_x_reg       <= f_x_next;
        g_found_reg   <= f_found_reg;
        g_invalid_reg <= f_invalid_reg;
        g_exact_reg   <= f_exact_reg;
        g_neg_reg     <= f_neg_reg;
        g_v1_reg      <= f_v1_reg;
        g_q_reg       <= prod[RECIP_SHIFT +: Q_W];
        vel_reg       <= vel_next;
        found_reg     <= g_found_reg && !g_invalid_reg;
        invalid_reg   <= g_invalid_reg;
    end

    assign done              = done_reg;
    assign unfolded_velocity = vel_reg;
    assign found             = found_reg;
    assign config_invalid    = invalid_reg;

endmodule

>>> design/dual_prf_velocity_dealias_unit.sv
// top level of the dual pulse-rate velocity dealias unit: registers and pipeline
// done is strobed for each accepted start; one pair accepted per cycle while busy is low
// the 8-stage match and rounding pipeline sets the latency; results cannot be stalled
// a register write starts the limit divider: busy is high until it is done (one bit per cycle)
// reset: registers take their reset values, the limit is preset to match, pipeline empty
`timescale 1ns / 1ps

module dual_prf_velocity_dealias_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [dpvd_pkg::VEL_W-1:0]     velocity_first,
    input  logic signed [dpvd_pkg::VEL_W-1:0]     velocity_second,
    output logic                                  done,
    output logic signed [dpvd_pkg::OUT_W-1:0]     unfolded_velocity,
    output logic                                  found,
    output logic                                  config_invalid,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dpvd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dpvd_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import dpvd_pkg::*;

    logic [NYQ_W-1:0] nyq_first_reg, nyq_first_next;
    logic [NYQ_W-1:0] nyq_second_reg, nyq_second_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [THR_W-1:0] thr_reg, thr_next;
    logic             cfg_write;
    logic             in_valid;
    logic             div_busy;
    logic [CAP_W-1:0] limit;
    pair_t            pair;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign busy      = div_busy;
    assign in_valid  = start && !div_busy;

    // register write decode
    always_comb
    begin
        nyq_first_next  = nyq_first_reg;
        nyq_second_next = nyq_second_reg;
        cap_next        = cap_reg;
        thr_next        = thr_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NYQ_FIRST:  nyq_first_next  = cfg_data[NYQ_W-1:0];
                REG_NYQ_SECOND: nyq_second_next = cfg_data[NYQ_W-1:0];
                REG_UNFOLD_CAP: cap_next        = cfg_data[CAP_W-1:0];
                REG_MATCH_THR:  thr_next        = cfg_data[THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nyq_first_reg  <= NYQ_W'(RST_NYQ_FIRST);
            nyq_second_reg <= NYQ_W'(RST_NYQ_SECOND);
            cap_reg        <= CAP_W'(RST_CAP);
            thr_reg        <= THR_W'(RST_THR);
        end
        else
        begin
            nyq_first_reg  <= nyq_first_next;
            nyq_second_reg <= nyq_second_next;
            cap_reg        <= cap_next;
            thr_reg        <= thr_next;
        end
    end

    // velocity limit from the two nyquist velocities and the cap
    dpvd_limit_div u_limit_div (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (cfg_write),
        .nyquist_first  (nyq_first_reg),
        .nyquist_second (nyq_second_reg),
        .unfold_cap     (cap_reg),
        .busy           (div_busy),
        .limit          (limit)
    );

    // candidate unfolding and pair selection
    dpvd_cand_match u_cand_match (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .velocity_first  (velocity_first),
        .velocity_second (velocity_second),
        .nyquist_first   (nyq_first_reg),
        .nyquist_second  (nyq_second_reg),
        .limit           (limit),
        .match_threshold (thr_reg),
        .pair            (pair)
    );

    // averaging, rounding and result register
    dpvd_round u_round (
        .clk               (clk),
        .rst_n             (rst_n),
        .pair              (pair),
        .done              (done),
        .unfolded_velocity (unfolded_velocity),
        .found             (found),
        .config_invalid    (config_invalid)
    );

endmodule
